@@ rtl/swm_pkg.sv @@
// swm_pkg: shared types and constants for the sliding window median filter.
// No dependencies; used by swm_ctrl, swm_datapath and the top level.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic remove;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
  } stat_t;

endpackage

@@ rtl/sliding_window_median.sv @@
// sliding_window_median: top level of the lower-median filter.
// Depends on swm_pkg, swm_ctrl and swm_datapath.
//
// Usage:
//   in_*  : one signed 32-bit sample per request (in_tdata), in_tuser = restart,
//           which empties the window before the sample enters.
//   out_* : one median per request once the window is full (window_size, 0 as 1, capped).
//   cfg_* : cfg_wen writes window_size (7 bits, reset 3) and empties the
//           window; write only while no request is in flight.
// Timing:
//   A request runs ring read, remove pass over the sorted cells, insert pass,
//   then output load; in_tready is high only while idle, so a new sample waits
//   for the last to finish, as the sorted cell array is shared. A median shows
//   on out_tvalid once loaded, and the load waits while a held result stays.
// Reset (rst_n low, synchronous): window empty, window_size 3, no result.
// Stall: a held result stays in the output register; the next sample is
//   still taken and worked, and its result waits for the register to drain.
module sliding_window_median #(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] median
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata
);

  swm_pkg::cmd_t                        cmd;
  swm_pkg::stat_t                       stat;
  logic signed [swm_pkg::SAMPLE_W-1:0]  median;

  swm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  swm_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_sample  ($signed(in_tdata)),
    .in_restart (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .median     (median)
  );

  assign out_tdata = $unsigned(median);

endmodule

@@ rtl/swm_ctrl.sv @@
// swm_ctrl: sequencer for the median filter (load, remove, insert, emit).
// Depends on swm_pkg; drives swm_datapath through cmd_t, reads stat_t.
module swm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output swm_pkg::cmd_t  cmd,
  input  swm_pkg::stat_t stat
);

  swm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = swm_pkg::ST_REMOVE;
        end
      end
      swm_pkg::ST_REMOVE: begin
        cmd.remove = stat.full;
        state_nxt  = swm_pkg::ST_INSERT;
      end
      swm_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = swm_pkg::ST_EMIT;
      end
      swm_pkg::ST_EMIT: begin
        if (!stat.full) begin
          state_nxt = swm_pkg::ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/swm_datapath.sv @@
// swm_datapath: arrival ring memory, compare-and-shift sorted cells,
// window size register and median output register. Depends on swm_pkg.
module swm_datapath #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wen,
  input  logic        [swm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_restart,
  input  swm_pkg::cmd_t                        cmd,
  output swm_pkg::stat_t                       stat,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  median
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = (KW > swm_pkg::CFG_W) ? KW : swm_pkg::CFG_W;

  logic        [swm_pkg::CFG_W-1:0]    window_size_r;
  logic        [KW-1:0]                fill_r;
  logic        [PW-1:0]                ptr_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] ring_q_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] median_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic signed [swm_pkg::SAMPLE_W-1:0] sorted_r [WINDOW_MAX];

  logic [CW-1:0]         ws_ext;
  logic [KW-1:0]         k;
  logic [PW-1:0]         mid;
  logic [PW-1:0]         ptr_base;
  logic [PW-1:0]         ptr_eff;
  logic [KW-1:0]         ptr_inc;
  logic [PW-1:0]         ptr_adv;
  logic [WINDOW_MAX-1:0] le;
  logic [WINDOW_MAX-1:0] ge;

  // effective window size: zero acts as one, clamp at capacity
  always_comb begin
    ws_ext = CW'(window_size_r);
    if (ws_ext == '0) begin
      k = KW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(ws_ext);
    end
    mid      = PW'((k - KW'(1)) >> 1);
    ptr_base = in_restart ? '0 : ptr_r;
    ptr_eff  = (KW'(ptr_base) >= k) ? '0 : ptr_base;
    ptr_inc  = KW'(ptr_r) + KW'(1);
    ptr_adv  = (ptr_inc >= k) ? '0 : PW'(ptr_inc);
  end

  assign stat.full = (fill_r == k);
  assign median    = median_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swm_pkg::CFG_RESET;
      fill_r        <= '0;
      ptr_r         <= '0;
    end else if (cfg_wen) begin
      window_size_r <= cfg_wdata;
      fill_r        <= '0;
      ptr_r         <= '0;
    end else if (cmd.load) begin
      if (in_restart) begin
        fill_r <= '0;
      end
      ptr_r <= ptr_eff;
    end else if (cmd.remove) begin
      fill_r <= fill_r - KW'(1);
    end else if (cmd.insert) begin
      fill_r <= fill_r + KW'(1);
      ptr_r  <= ptr_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      ring_q_r <= ring_mem[ptr_eff];
    end
    if (cmd.insert) begin
      ring_mem[ptr_r] <= sample_r;
    end
    if (cmd.emit) begin
      median_r <= sorted_r[mid];
    end
  end

  // on remove each cell decides from its own compare: sorted order makes the
  // first match of the leaving value the first cell >= it; insert also reads le[i-1]
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign le[i] = (KW'(i) < fill_r) && (sorted_r[i] <= sample_r);
    assign ge[i] = (sorted_r[i] >= ring_q_r);

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.remove) begin
          if (ge[i] && (WINDOW_MAX > 1)) begin
            sorted_r[i] <= sorted_r[(i + 1) % WINDOW_MAX];
          end
        end else if (cmd.insert) begin
          if (!le[i]) begin
            sorted_r[i] <= sample_r;
          end
        end
      end
    end else if (i == WINDOW_MAX - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.insert && !le[i]) begin
          sorted_r[i] <= le[i-1] ? sample_r : sorted_r[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.remove) begin
          if (ge[i]) begin
            sorted_r[i] <= sorted_r[i+1];
          end
        end else if (cmd.insert) begin
          if (!le[i]) begin
            sorted_r[i] <= le[i-1] ? sample_r : sorted_r[i-1];
          end
        end
      end
    end
  end

endmodule

@@ rtl/swm_checker.sv @@
// swm_assertions: port-level checks for sliding_window_median, with its bind.
// Depends only on the top level's ports.
module swm_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after request");

endmodule

bind sliding_window_median swm_assertions u_swm_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/swm_checker.sv @@
// swm_checker: watches the sample, median and config ports of sliding_window_median,
// predicts each median and compares it with what the block delivers.
// Depends on swm_pkg.
module swm_checker #(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tuser,   // [0] restart
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] median
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          medians_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [swm_pkg::SAMPLE_W-1:0] sample_t;

  sample_t                   sorted_vals[WINDOW_MAX];
  sample_t                   arrival[WINDOW_MAX];
  int unsigned               fill;
  int unsigned               oldest;
  logic [swm_pkg::CFG_W-1:0] win_size;
  sample_t                   median_q[$];
  sample_t                   want;
  int                        mismatches;
  int                        checked;

  assign fail_count      = mismatches;
  assign medians_checked = checked;

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatches++;
  endtask

  // drop the oldest sample once full, insert the new one, queue the lower median
  task automatic slide_window(input sample_t s, input logic restart);
    int unsigned k;
    int unsigned i;
    k = (win_size == 0) ? 1 : ((win_size > WINDOW_MAX) ? WINDOW_MAX : win_size);
    if (restart) begin
      fill   = 0;
      oldest = 0;
    end
    if (oldest >= k) oldest = 0;
    if (fill >= k) begin
      i = 0;
      while (i < fill && sorted_vals[i] != arrival[oldest]) i++;
      if (i < fill) begin
        while (i + 1 < fill) begin
          sorted_vals[i] = sorted_vals[i+1];
          i++;
        end
        fill--;
      end
    end
    if (fill < WINDOW_MAX) begin
      i = fill;
      while (i > 0 && sorted_vals[i-1] > s) begin
        sorted_vals[i] = sorted_vals[i-1];
        i--;
      end
      sorted_vals[i] = s;
      fill++;
    end
    arrival[oldest] = s;
    oldest = (oldest + 1 >= k) ? 0 : oldest + 1;
    if (fill == k) median_q.push_back(sorted_vals[(k-1) >> 1]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill     = 0;
      oldest   = 0;
      win_size = swm_pkg::CFG_RESET;
      median_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("median %0d with none expected", $signed(out_tdata)));
        end else begin
          want = median_q.pop_front();
          checked++;
          if (out_tdata !== want)
            report_mismatch($sformatf("median got %0d want %0d", $signed(out_tdata), want));
        end
      end
      if (cfg_wen) begin
        win_size = cfg_wdata;
        fill     = 0;
        oldest   = 0;
      end
      if (in_tvalid && in_tready) slide_window($signed(in_tdata), in_tuser);
    end
    pending <= median_q.size();
  end

endmodule

@@ bench/tb_sliding_window_median.sv @@
// tb_sliding_window_median: stimulus and verdict for the sliding window median filter.
// Depends on swm_pkg, sliding_window_median and swm_checker.
module tb_sliding_window_median;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [swm_pkg::SAMPLE_W-1:0] sample_t;

  localparam int LIMIT    = 400000;
  localparam int HOLD_LEN = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] sample
  logic        in_tuser;   // [0] restart
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] median
  logic        cfg_wen;
  logic [6:0]  cfg_wdata;

  int fail_count;
  int pending;
  int medians_checked;
  int cycles;
  int items_sent;
  int n_settings;
  bit calm;
  bit hold_req;

  sliding_window_median u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  swm_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .medians_checked (medians_checked)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // median sink: random back-pressure, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  function automatic sample_t pick_sample();
    sample_t edges[4];
    edges = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1};
    case ($urandom_range(9))
      0:       return edges[$urandom_range(3)];
      1, 2, 3: return sample_t'($urandom_range(15)) - 32'sd8;  // dense, many ties
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input sample_t s, input bit restart);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic set_window(input logic [swm_pkg::CFG_W-1:0] v);
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    n_settings++;
  endtask

  task automatic run_window(input logic [swm_pkg::CFG_W-1:0] v, input int n,
                            input int restart_pct,
                            input bit hold, input bit drain, input bit quiet);
    bit rs;
    set_window(v);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if (hold && i == 10) hold_req = 1'b1;
      if (drain && i == n / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      rs = ($urandom_range(99) < restart_pct) || (restart_pct == 0 && i == n / 4);
      push_sample(pick_sample(), rs);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
  endtask

  initial begin
    sample_t dir_s[20];
    bit      dir_r[20];
    dir_s = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1, 32'sd7, 32'sd7, 32'sd7,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sd5, 32'sd3,
              -32'sd5, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd0, 32'sd0, 32'sd0};
    dir_r = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0};
    items_sent = 0;
    n_settings = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 3: extremes, ties, restarts
    for (int i = 0; i < 20; i++) push_sample(dir_s[i], dir_r[i]);
    in_tvalid <= 1'b0;

    run_window(7'd1,   60,  4, 1'b0, 1'b0, 1'b0);
    run_window(7'd0,   40,  4, 1'b0, 1'b0, 1'b0);
    run_window(7'd2,   80,  4, 1'b0, 1'b1, 1'b0);
    run_window(7'd64,  200, 0, 1'b0, 1'b0, 1'b0);
    run_window(7'd127, 150, 0, 1'b0, 1'b0, 1'b0);
    run_window(7'd5,   100, 4, 1'b1, 1'b0, 1'b0);
    run_window(7'd4,   80,  4, 1'b0, 1'b0, 1'b1);
    run_window(7'd100, 100, 0, 1'b0, 1'b0, 1'b0);
    run_window(7'($urandom_range(40, 6)), 100, 2, 1'b0, 1'b0, 1'b0);

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d samples over %0d window writes (0, 1, 2, 64, above range, random).",
             items_sent, n_settings);
    $display("Checked %0d medians, with a long output hold and a mid-stream drain.",
             medians_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/swm_pkg.sv
rtl/swm_ctrl.sv
rtl/swm_datapath.sv
rtl/sliding_window_median.sv
rtl/swm_checker.sv
bench/swm_checker.sv
bench/tb_sliding_window_median.sv
